// ===== rtl/vbp_pkg.sv =====
package vbp_pkg;

    // Header layout
    localparam int VBP_HEADER_BYTES = 26;
    localparam int VBP_SIG_BYTES    = 20;
    localparam int VBP_OFS_LO_POS   = 20;
    localparam int VBP_OFS_HI_POS   = 21;

    // Sample rate arithmetic
    localparam int VBP_RATE_NUM   = 1000000;
    localparam int VBP_TC_BASE    = 256;
    localparam int VBP_ROUND_ADD  = 99;
    localparam int VBP_ROUND_STEP = 100;
    localparam int VBP_DIV_STEPS  = 20;
    // x / 100 as (x * ceil(2^27 / 100)) >> 27, exact for any 20-bit x
    localparam int VBP_ROUND_RECIP = 1342178;
    localparam int VBP_ROUND_SHIFT = 27;

    // Queue between parser and output side
    localparam int VBP_FIFO_DEPTH = 4;

    // Block types and codec
    localparam logic [7:0] VBP_TYPE_END   = 8'h00;
    localparam logic [7:0] VBP_TYPE_AUDIO = 8'h01;
    localparam logic [7:0] VBP_CODEC_PCM8 = 8'h00;
    localparam logic [7:0] VBP_SIGN_FLIP  = 8'h80;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_SKIP,
        PH_TYPE,
        PH_LEN,
        PH_TC,
        PH_CODEC,
        PH_SAMPLES,
        PH_BODY,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_AUDIO,
        ST_SHORT,
        ST_SIGNATURE,
        ST_OFFSET,
        ST_TRUNCATED,
        ST_CODEC,
        ST_LENGTH
    } t_status;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_RATE,
        KIND_STATUS
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV_TC,
        BK_DIV_ROUND,
        BK_SCALE
    } t_back_state;

    // One queued transaction: data is a sample byte or a time constant
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_entry;

    // Expected signature bytes
    function automatic logic [7:0] vbp_sig_byte(input logic [4:0] idx);
        logic [7:0] v;
        unique case (idx)
            5'd0:    v = 8'h43;
            5'd1:    v = 8'h72;
            5'd2:    v = 8'h65;
            5'd3:    v = 8'h61;
            5'd4:    v = 8'h74;
            5'd5:    v = 8'h69;
            5'd6:    v = 8'h76;
            5'd7:    v = 8'h65;
            5'd8:    v = 8'h20;
            5'd9:    v = 8'h56;
            5'd10:   v = 8'h6F;
            5'd11:   v = 8'h69;
            5'd12:   v = 8'h63;
            5'd13:   v = 8'h65;
            5'd14:   v = 8'h20;
            5'd15:   v = 8'h46;
            5'd16:   v = 8'h69;
            5'd17:   v = 8'h6C;
            5'd18:   v = 8'h65;
            5'd19:   v = 8'h1A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/vbp_if.sv =====
// Byte stream into the parser
interface vbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;

    modport source (output valid, output file_byte, input ready);
    modport sink   (input valid, input file_byte, output ready);
endinterface

// Parser results
interface vbp_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [19:0]        sample_rate;
    logic [2:0]         status;
    logic               last;

    modport source (output valid, output kind, output sample, output sample_rate,
                    output status, output last, input ready);
    modport sink   (input valid, input kind, input sample, input sample_rate,
                    input status, input last, output ready);
endinterface

// ===== rtl/vbp_fifo.sv =====
module vbp_fifo #(
    parameter int P_DEPTH = vbp_pkg::VBP_FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vbp_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output vbp_pkg::t_entry o_entry,
    output logic            o_empty
);
    import vbp_pkg::*;

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_entry          r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic w_push, w_pop;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/vbp_front.sv =====
module vbp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_wdata,
    vbp_byte_if.sink        i_byte,
    output logic            o_push,
    output vbp_pkg::t_entry o_entry,
    input  logic            i_full
);
    import vbp_pkg::*;

    logic [31:0] r_file_size;
    t_phase      r_phase, n_phase, w_phase_step;
    logic [31:0] r_pos, n_pos;
    logic [15:0] r_data_start, n_data_start;
    logic        r_sig_ok, n_sig_ok;
    logic [23:0] r_blk_len, n_blk_len;
    logic [23:0] r_left, n_left;
    logic        r_is_audio, n_is_audio;
    logic [7:0]  r_tc, n_tc;
    t_status     r_done_st, n_done_st, w_done_st_step;

    logic        w_accept;
    logic [7:0]  w_b;
    logic [32:0] w_next;
    logic        w_eof;
    logic [33:0] w_blk_end;

    assign i_byte.ready = !i_full;
    assign w_accept     = i_byte.valid && !i_full;
    assign w_b          = i_byte.file_byte;
    assign w_next       = {1'b0, r_pos} + 33'd1;
    assign w_eof        = (w_next >= {1'b0, r_file_size});
    assign w_blk_end    = {1'b0, w_next} + {10'b0, n_blk_len};

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
        end else if (i_cfg_we) begin
            r_file_size <= i_cfg_wdata;
        end
    end

    // Next state of the parser for the byte on the input
    always_comb begin
        w_phase_step   = r_phase;
        w_done_st_step = r_done_st;
        n_data_start   = r_data_start;
        n_sig_ok       = r_sig_ok;
        n_blk_len      = r_blk_len;
        n_left         = r_left;
        n_is_audio     = r_is_audio;
        n_tc           = r_tc;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos < 32'(VBP_SIG_BYTES)) begin
                    if (w_b != vbp_sig_byte(r_pos[4:0])) begin
                        n_sig_ok = 1'b0;
                    end
                end else if (r_pos == 32'(VBP_OFS_LO_POS)) begin
                    n_data_start = {8'h00, w_b};
                end else if (r_pos == 32'(VBP_OFS_HI_POS)) begin
                    n_data_start = {w_b, r_data_start[7:0]};
                end
                if (r_pos >= 32'(VBP_HEADER_BYTES - 1)) begin
                    w_phase_step = PH_DONE;
                    priority if (r_file_size < 32'(VBP_HEADER_BYTES)) begin
                        w_done_st_step = ST_SHORT;
                    end else if (!n_sig_ok) begin
                        w_done_st_step = ST_SIGNATURE;
                    end else if (n_data_start < 16'(VBP_HEADER_BYTES) ||
                                 {16'h0000, n_data_start} >= r_file_size) begin
                        w_done_st_step = ST_OFFSET;
                    end else if (n_data_start == 16'(VBP_HEADER_BYTES)) begin
                        w_phase_step = PH_TYPE;
                    end else begin
                        w_phase_step = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (w_next >= {17'h0, r_data_start}) begin
                    w_phase_step = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (w_b == VBP_TYPE_END) begin
                    w_phase_step   = PH_DONE;
                    w_done_st_step = ST_NO_AUDIO;
                end else begin
                    n_is_audio   = (w_b == VBP_TYPE_AUDIO);
                    n_blk_len    = '0;
                    n_left       = '0;
                    w_phase_step = PH_LEN;
                end
            end
            PH_LEN: begin
                // little-endian 24-bit length, byte count kept in r_left
                unique case (r_left[1:0])
                    2'd0:    n_blk_len[7:0]   = w_b;
                    2'd1:    n_blk_len[15:8]  = w_b;
                    default: n_blk_len[23:16] = w_b;
                endcase
                n_left = r_left + 24'd1;
                if (r_left[1:0] == 2'd2) begin
                    priority if (w_blk_end > {2'b00, r_file_size}) begin
                        w_phase_step   = PH_DONE;
                        w_done_st_step = ST_TRUNCATED;
                    end else if (r_is_audio) begin
                        if (n_blk_len < 24'd2) begin
                            w_phase_step   = PH_DONE;
                            w_done_st_step = ST_LENGTH;
                        end else begin
                            n_left       = n_blk_len - 24'd2;
                            w_phase_step = PH_TC;
                        end
                    end else if (n_blk_len == '0) begin
                        w_phase_step = PH_TYPE;
                    end else begin
                        n_left       = n_blk_len;
                        w_phase_step = PH_BODY;
                    end
                end
            end
            PH_TC: begin
                n_tc         = w_b;
                w_phase_step = PH_CODEC;
            end
            PH_CODEC: begin
                w_phase_step = PH_DONE;
                if (w_b != VBP_CODEC_PCM8) begin
                    w_done_st_step = ST_CODEC;
                end else if (r_left == '0) begin
                    w_done_st_step = ST_OK;
                end else begin
                    w_phase_step = PH_SAMPLES;
                end
            end
            PH_SAMPLES: begin
                n_left = r_left - 24'd1;
                if (n_left == '0) begin
                    w_phase_step   = PH_DONE;
                    w_done_st_step = ST_OK;
                end
            end
            PH_BODY: begin
                n_left = r_left - 24'd1;
                if (n_left == '0) begin
                    w_phase_step = PH_TYPE;
                end
            end
            default: begin
                w_phase_step = r_phase;
            end
        endcase

        // End of file rearms for the next one
        n_phase   = w_phase_step;
        n_done_st = w_done_st_step;
        n_pos     = w_next[31:0];
        if (w_eof) begin
            n_phase      = PH_HEADER;
            n_done_st    = ST_OK;
            n_pos        = '0;
            n_data_start = '0;
            n_sig_ok     = 1'b1;
            n_blk_len    = '0;
            n_left       = '0;
            n_is_audio   = 1'b0;
            n_tc         = '0;
        end
    end

    // Transaction pushed to the queue
    always_comb begin
        o_entry.kind   = KIND_STATUS;
        o_entry.data   = w_b;
        o_entry.status = ST_OK;
        o_entry.last   = w_eof;
        if (r_phase == PH_CODEC && w_b == VBP_CODEC_PCM8) begin
            o_entry.kind = KIND_RATE;
            o_entry.data = r_tc;
        end else if (r_phase == PH_SAMPLES) begin
            o_entry.kind = KIND_SAMPLE;
        end
        if (w_eof) begin
            priority case (w_phase_step)
                PH_DONE:   o_entry.status = w_done_st_step;
                PH_HEADER: o_entry.status = ST_SHORT;
                PH_TYPE:   o_entry.status = ST_NO_AUDIO;
                default:   o_entry.status = ST_TRUNCATED;
            endcase
        end
        o_push = w_accept && (w_eof || o_entry.kind != KIND_STATUS);
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_done_st    <= ST_OK;
            r_pos        <= '0;
            r_data_start <= '0;
            r_sig_ok     <= 1'b1;
            r_blk_len    <= '0;
            r_left       <= '0;
            r_is_audio   <= 1'b0;
            r_tc         <= '0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_done_st    <= n_done_st;
            r_pos        <= n_pos;
            r_data_start <= n_data_start;
            r_sig_ok     <= n_sig_ok;
            r_blk_len    <= n_blk_len;
            r_left       <= n_left;
            r_is_audio   <= n_is_audio;
            r_tc         <= n_tc;
        end
    end

endmodule

// ===== rtl/vbp_back.sv =====
module vbp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vbp_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    vbp_result_if.source    o_result
);
    import vbp_pkg::*;

    localparam int CNTW = $clog2(VBP_DIV_STEPS);

    t_back_state r_state, n_state;
    logic [8:0]  r_rem;
    logic [19:0] r_quo;
    logic [8:0]  r_div;
    logic [CNTW-1:0] r_cnt;
    logic        r_last;
    t_status     r_status;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic signed [15:0] r_out_sample;
    logic [19:0]        r_out_rate;
    t_status            r_out_status;
    logic               r_out_last;

    logic        w_out_free;
    logic        w_step_done;
    logic [9:0]  w_rem_sh;
    logic        w_ge;
    logic [8:0]  w_rem_new;
    logic [19:0] w_quo_new;
    logic [40:0] w_round_prod;
    logic [19:0] w_round_quo;
    logic        w_load_rate;
    logic        w_load_direct;
    logic        w_load_scaled;

    assign w_out_free  = !r_out_valid || o_result.ready;
    assign w_step_done = (r_cnt == CNTW'(VBP_DIV_STEPS - 1));

    // One restoring division step a cycle
    assign w_rem_sh  = {r_rem, r_quo[19]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_new = w_ge ? 9'(w_rem_sh - {1'b0, r_div}) : w_rem_sh[8:0];
    assign w_quo_new = {r_quo[18:0], w_ge};

    // Divide by 100 with a reciprocal multiply
    assign w_round_prod = {21'b0, r_quo} * 41'(VBP_ROUND_RECIP);
    assign w_round_quo  = 20'(w_round_prod >> VBP_ROUND_SHIFT);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty && w_out_free && i_entry.kind == KIND_RATE) begin
                    n_state = BK_DIV_TC;
                end
            end
            BK_DIV_TC: begin
                if (w_step_done) n_state = BK_DIV_ROUND;
            end
            BK_DIV_ROUND: begin
                n_state = BK_SCALE;
            end
            BK_SCALE: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop         = 1'b0;
        w_load_rate   = 1'b0;
        w_load_direct = 1'b0;
        w_load_scaled = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty && w_out_free) begin
                    o_pop = 1'b1;
                    if (i_entry.kind == KIND_RATE) begin
                        w_load_rate = 1'b1;
                    end else begin
                        w_load_direct = 1'b1;
                    end
                end
            end
            BK_SCALE: begin
                w_load_scaled = 1'b1;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider: 1000000 / (256 - tc), then (q + 99) / 100 by reciprocal
    always_ff @(posedge i_clk) begin
        if (w_load_rate) begin
            r_rem    <= '0;
            r_quo    <= 20'(VBP_RATE_NUM);
            r_div    <= 9'(VBP_TC_BASE) - {1'b0, i_entry.data};
            r_cnt    <= '0;
            r_last   <= i_entry.last;
            r_status <= i_entry.status;
        end else if (r_state == BK_DIV_TC) begin
            if (w_step_done) begin
                r_cnt <= '0;
                r_quo <= w_quo_new + 20'(VBP_ROUND_ADD);
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_rem <= w_rem_new;
                r_quo <= w_quo_new;
            end
        end else if (r_state == BK_DIV_ROUND) begin
            r_quo <= w_round_quo;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_direct || w_load_scaled) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_direct) begin
            r_out_kind   <= i_entry.kind;
            r_out_sample <= (i_entry.kind == KIND_SAMPLE) ?
                            {i_entry.data ^ VBP_SIGN_FLIP, 8'h00} : 16'sd0;
            r_out_rate   <= '0;
            r_out_status <= i_entry.status;
            r_out_last   <= i_entry.last;
        end else if (w_load_scaled) begin
            // quotient times 100
            r_out_kind   <= KIND_RATE;
            r_out_sample <= 16'sd0;
            r_out_rate   <= (r_quo << 6) + (r_quo << 5) + (r_quo << 2);
            r_out_status <= r_status;
            r_out_last   <= r_last;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.kind        = r_out_kind;
    assign o_result.sample      = r_out_sample;
    assign o_result.sample_rate = r_out_rate;
    assign o_result.status      = r_out_status;
    assign o_result.last        = r_out_last;

endmodule

// ===== rtl/voc_block_parser_pcm8.sv =====
// Voice-format audio file parser, 8-bit PCM.
// i_byte carries the file one byte per transaction (valid/ready); i_cfg_we
// with i_cfg_wdata sets the file size in bytes, written between files.
// o_result gives one transaction per sample and one for the sample rate;
// the file's final transaction, of any kind, has last set and the file's status.
// A parsing front end takes one byte per cycle while the queue has room and
// pushes results into a small queue; an output stage drains the queue into
// a registered output, so each result passes the queue and then the output
// register. The sample rate needs a 20-step restoring division, a reciprocal
// multiply for the rounding and a scaling step; bytes keep being taken until
// the queue fills, after which i_byte.ready drops until the rate is out.
// Otherwise throughput is one byte per cycle.
// Reset (i_rst_n low at a clock edge) clears the file size to zero, the
// parser to the start of a header and empties the queue and output.
// When the receiver holds o_result.ready low, the output register holds its
// transaction, the queue fills and i_byte.ready falls; nothing is dropped.
module voc_block_parser_pcm8 #(
    parameter int P_FIFO_DEPTH = vbp_pkg::VBP_FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    vbp_byte_if.sink      i_byte,
    vbp_result_if.source  o_result
);
    import vbp_pkg::*;

    logic   w_push, w_full, w_pop, w_empty;
    t_entry w_push_entry, w_pop_entry;

    // Byte parser
    vbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (i_byte),
        .o_push      (w_push),
        .o_entry     (w_push_entry),
        .i_full      (w_full)
    );

    // Decoupling queue
    vbp_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_empty (w_empty)
    );

    // Result formatting and rate divider
    vbp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (w_pop_entry),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule

// ===== tb/voc_block_parser_pcm8_test.sv =====
`timescale 1ns / 100ps

module voc_block_parser_pcm8_test;
    import vbp_pkg::*;

    localparam int IDLE_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BYTES   = 1000;

    // 20-byte file signature, first byte in the top bits
    localparam logic [159:0] VOC_MAGIC = 160'h4372_6561_7469_7665_2056_6F69_6365_2046_696C_651A;

    typedef struct {
        t_kind              kind;
        logic signed [15:0] sample;
        logic [19:0]        sample_rate;
        t_status            status;
        logic               last;
    } t_voc_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    vbp_byte_if   byte_if ();
    vbp_result_if res_if ();

    voc_block_parser_pcm8 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (byte_if),
        .o_result    (res_if)
    );

    // Parser tracking state
    t_phase      par_phase;
    t_status     par_verdict;
    logic [31:0] par_size;
    logic [31:0] par_pos;
    logic [15:0] par_offset;
    logic        par_sig_ok;
    logic [23:0] par_blk_len;
    logic [23:0] par_blk_left;
    logic        par_is_audio;
    logic [7:0]  par_tc;

    t_voc_result parse_results_due[$];
    logic [7:0]  file_bytes[$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    bit          steady;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Gap length for either side: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic void rearm_parser();
        par_phase    = PH_HEADER;
        par_verdict  = ST_OK;
        par_pos      = '0;
        par_offset   = '0;
        par_sig_ok   = 1'b1;
        par_blk_len  = '0;
        par_blk_left = '0;
        par_is_audio = 1'b0;
        par_tc       = '0;
    endfunction

    function automatic void settle(input t_status s);
        par_phase   = PH_DONE;
        par_verdict = s;
    endfunction

    // Advance the tracking parser by one accepted byte, queue what it should give
    task automatic parse_byte(input logic [7:0] b);
        logic [32:0] nxt;
        logic [33:0] blk_end;
        logic        give;
        t_voc_result r;
        nxt           = {1'b0, par_pos} + 33'd1;
        give          = 1'b0;
        r.kind        = KIND_STATUS;
        r.sample      = '0;
        r.sample_rate = '0;
        r.status      = ST_OK;
        r.last        = 1'b0;
        case (par_phase)
            PH_HEADER: begin
                if (par_pos < VBP_SIG_BYTES) begin
                    if (b != VOC_MAGIC[159 - 8 * int'(par_pos) -: 8]) par_sig_ok = 1'b0;
                end else if (par_pos == VBP_OFS_LO_POS) begin
                    par_offset = {8'h00, b};
                end else if (par_pos == VBP_OFS_HI_POS) begin
                    par_offset[15:8] = b;
                end
                if (par_pos >= VBP_HEADER_BYTES - 1) begin
                    if (par_size < VBP_HEADER_BYTES) settle(ST_SHORT);
                    else if (!par_sig_ok) settle(ST_SIGNATURE);
                    else if (par_offset < VBP_HEADER_BYTES || par_offset >= par_size)
                        settle(ST_OFFSET);
                    else if (par_offset == VBP_HEADER_BYTES) par_phase = PH_TYPE;
                    else par_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (nxt >= par_offset) par_phase = PH_TYPE;
            end
            PH_TYPE: begin
                if (b == VBP_TYPE_END) begin
                    settle(ST_NO_AUDIO);
                end else begin
                    par_is_audio = (b == VBP_TYPE_AUDIO);
                    par_blk_len  = '0;
                    par_blk_left = '0;
                    par_phase    = PH_LEN;
                end
            end
            PH_LEN: begin
                par_blk_len  = par_blk_len | (24'(b) << (8 * par_blk_left[1:0]));
                par_blk_left = par_blk_left + 24'd1;
                if (par_blk_left >= 3) begin
                    blk_end = 34'(nxt) + 34'(par_blk_len);
                    if (blk_end > 34'(par_size)) begin
                        settle(ST_TRUNCATED);
                    end else if (par_is_audio) begin
                        if (par_blk_len < 2) begin
                            settle(ST_LENGTH);
                        end else begin
                            par_blk_left = par_blk_len - 24'd2;
                            par_phase    = PH_TC;
                        end
                    end else if (par_blk_len == 0) begin
                        par_phase = PH_TYPE;
                    end else begin
                        par_blk_left = par_blk_len;
                        par_phase    = PH_BODY;
                    end
                end
            end
            PH_TC: begin
                par_tc    = b;
                par_phase = PH_CODEC;
            end
            PH_CODEC: begin
                if (b != VBP_CODEC_PCM8) begin
                    settle(ST_CODEC);
                end else begin
                    give          = 1'b1;
                    r.kind        = KIND_RATE;
                    // rate rounded up to the next 100 Hz
                    r.sample_rate = 20'((((VBP_RATE_NUM / (VBP_TC_BASE - int'(par_tc)))
                                    + VBP_ROUND_ADD) / VBP_ROUND_STEP) * VBP_ROUND_STEP);
                    if (par_blk_left == 0) settle(ST_OK);
                    else par_phase = PH_SAMPLES;
                end
            end
            PH_SAMPLES: begin
                give         = 1'b1;
                r.kind       = KIND_SAMPLE;
                r.sample     = {b ^ VBP_SIGN_FLIP, 8'h00};
                par_blk_left = par_blk_left - 24'd1;
                if (par_blk_left == 0) settle(ST_OK);
            end
            PH_BODY: begin
                par_blk_left = par_blk_left - 24'd1;
                if (par_blk_left == 0) par_phase = PH_TYPE;
            end
            default: ;
        endcase
        // End of file: final status rides on this transaction
        if (nxt >= 33'(par_size)) begin
            r.last = 1'b1;
            if (par_phase == PH_DONE) r.status = par_verdict;
            else if (par_phase == PH_HEADER) r.status = ST_SHORT;
            else if (par_phase == PH_TYPE) r.status = ST_NO_AUDIO;
            else r.status = ST_TRUNCATED;
            give = 1'b1;
            rearm_parser();
        end else begin
            par_pos = nxt[31:0];
        end
        if (give) parse_results_due.push_back(r);
    endtask

    function automatic void flag_field(input string what, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        fail_count++;
    endfunction

    task automatic check_result();
        t_voc_result want;
        if (parse_results_due.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual kind %0d status %0d",
                     $time, res_if.kind, res_if.status);
            fail_count++;
        end else begin
            want = parse_results_due.pop_front();
            if (res_if.kind !== want.kind) flag_field("kind", want.kind, res_if.kind);
            if (res_if.sample !== want.sample) flag_field("sample", want.sample, res_if.sample);
            if (res_if.sample_rate !== want.sample_rate)
                flag_field("sample_rate", want.sample_rate, res_if.sample_rate);
            if (res_if.status !== want.status) flag_field("status", want.status, res_if.status);
            if (res_if.last !== want.last) flag_field("last", want.last, res_if.last);
        end
    endtask

    // Result side: random back-pressure, check every transaction taken
    initial begin
        int unsigned hold;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) check_result();
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                hold--;
            end else begin
                res_if.ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.file_byte <= b;
        @(posedge i_clk);
        while (byte_if.ready !== 1'b1) @(posedge i_clk);
        parse_byte(b);
    endtask

    // Stop sending, drain all results, then let the rate divider settle
    task automatic wait_idle();
        byte_if.valid <= 1'b0;
        while (parse_results_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_file_size(input logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        par_size = v;
    endtask

    task automatic stream_file(input logic [31:0] size);
        int i;
        wait_idle();
        write_file_size(size);
        for (i = 0; i < file_bytes.size(); i++) push_byte(file_bytes[i]);
    endtask

    // File builders
    task automatic add_random(input int unsigned n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endtask

    task automatic start_file(input logic [15:0] ofs, input int flip_at);
        int i;
        file_bytes.delete();
        for (i = 0; i < VBP_SIG_BYTES; i++) file_bytes.push_back(VOC_MAGIC[159 - 8 * i -: 8]);
        if (flip_at >= 0)
            file_bytes[flip_at] = file_bytes[flip_at] ^ 8'($urandom_range(255, 1));
        file_bytes.push_back(ofs[7:0]);
        file_bytes.push_back(ofs[15:8]);
        add_random(4);
        if (ofs > VBP_HEADER_BYTES && ofs < 256) add_random(ofs - VBP_HEADER_BYTES);
    endtask

    task automatic add_block_head(input logic [7:0] blk_type, input logic [23:0] len);
        file_bytes.push_back(blk_type);
        file_bytes.push_back(len[7:0]);
        file_bytes.push_back(len[15:8]);
        file_bytes.push_back(len[23:16]);
    endtask

    task automatic add_audio(input logic [23:0] len, input logic [7:0] tc,
                             input logic [7:0] codec);
        add_block_head(VBP_TYPE_AUDIO, len);
        if (len >= 1) file_bytes.push_back(tc);
        if (len >= 2) file_bytes.push_back(codec);
        if (len > 2) add_random(len - 2);
    endtask

    // Register extremes: every byte of a size-0 or size-1 file ends it
    task automatic test_tiny_files();
        file_bytes = '{8'h00, 8'hFF};
        stream_file(32'd0);
        file_bytes = '{8'h43};
        stream_file(32'd1);
    endtask

    task automatic test_clean_audio();
        // slowest rate, samples at both ends and the midpoint, file ends on a sample
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_block_head(VBP_TYPE_AUDIO, 24'd5);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(VBP_CODEC_PCM8);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h80);
        stream_file(file_bytes.size());
        // skip to offset, step over other blocks, rate only, trailing bytes
        start_file(16'd30, -1);
        add_block_head(8'h02, 24'd0);
        add_block_head(8'hFF, 24'd2);
        add_random(2);
        add_audio(24'd2, 8'hFF, VBP_CODEC_PCM8);
        add_random(2);
        stream_file(file_bytes.size());
        // file ends on the rate transaction
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_audio(24'd2, 8'h80, VBP_CODEC_PCM8);
        stream_file(file_bytes.size());
    endtask

    task automatic test_header_faults();
        start_file(16'(VBP_HEADER_BYTES), 19);
        add_audio(24'd4, 8'h10, VBP_CODEC_PCM8);
        stream_file(file_bytes.size());
        // offset inside the header
        start_file(16'd25, -1);
        add_random(6);
        stream_file(file_bytes.size());
        // offset beyond the file
        start_file(16'hFFFF, -1);
        add_random(6);
        stream_file(file_bytes.size());
        // file ends inside the header
        start_file(16'(VBP_HEADER_BYTES), -1);
        file_bytes = file_bytes[0:24];
        stream_file(file_bytes.size());
    endtask

    task automatic test_block_faults();
        // terminator block
        start_file(16'(VBP_HEADER_BYTES), -1);
        file_bytes.push_back(VBP_TYPE_END);
        add_random(3);
        stream_file(file_bytes.size());
        // file ends right after a complete block
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_block_head(8'h07, 24'd3);
        add_random(3);
        stream_file(file_bytes.size());
        // block length past the end of file
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_block_head(8'h02, 24'hFFFFFF);
        add_random(3);
        stream_file(file_bytes.size());
        // audio block too short, both lengths
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_audio(24'd1, 8'h10, VBP_CODEC_PCM8);
        add_random(2);
        stream_file(file_bytes.size());
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_audio(24'd0, 8'h10, VBP_CODEC_PCM8);
        add_random(2);
        stream_file(file_bytes.size());
        // unsupported codec
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_audio(24'd6, 8'h20, 8'h01);
        stream_file(file_bytes.size());
        // file ends inside a block header
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_block_head(VBP_TYPE_AUDIO, 24'd8);
        file_bytes = file_bytes[0:27];
        stream_file(file_bytes.size());
    endtask

    // Size lowered below the position mid-file: the next byte closes it
    task automatic test_size_rewrite();
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_block_head(8'h02, 24'd8);
        add_random(3);
        stream_file(32'hFFFF_FFFF);
        wait_idle();
        write_file_size(32'd5);
        push_byte(8'($urandom));
        // closing byte is also a sample
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_audio(24'd10, 8'h40, VBP_CODEC_PCM8);
        file_bytes = file_bytes[0:33];
        stream_file(32'hFFFF_FFFF);
        wait_idle();
        write_file_size(32'd3);
        push_byte(8'($urandom));
        // closing while waiting for a block type
        start_file(16'(VBP_HEADER_BYTES), -1);
        add_block_head(8'h02, 24'd0);
        stream_file(32'hFFFF_FFFF);
        wait_idle();
        write_file_size(32'd0);
        push_byte(8'($urandom));
    endtask

    // Mostly well-formed files with random content; fault picks a way to break one
    task automatic build_random_file(input int fault);
        logic [15:0] ofs;
        int          len;
        ofs = ($urandom_range(3) == 0) ? 16'($urandom_range(40, 27)) : 16'(VBP_HEADER_BYTES);
        if (fault == 2)
            ofs = $urandom_range(1) ? 16'($urandom_range(25)) : 16'($urandom_range(65535, 200));
        start_file(ofs, (fault == 1) ? int'($urandom_range(19)) : -1);
        repeat ($urandom_range(2)) begin
            len = $urandom_range(6);
            add_block_head(8'($urandom_range(255, 2)), 24'(len));
            add_random(len);
        end
        case (fault)
            3: add_audio(24'($urandom_range(12, 2)), 8'($urandom), 8'($urandom_range(255, 1)));
            4: add_audio(24'($urandom_range(1)), 8'($urandom), VBP_CODEC_PCM8);
            5: begin
                add_block_head(8'($urandom_range(255, 2)), 24'($urandom_range(24'hFFFFFF, 200)));
                add_random(4);
            end
            6: begin
                file_bytes.push_back(VBP_TYPE_END);
                add_random($urandom_range(4));
            end
            default: begin
                len = ($urandom_range(7) == 0) ? $urandom_range(80, 25) : $urandom_range(20, 2);
                add_audio(24'(len), 8'($urandom), VBP_CODEC_PCM8);
                add_random($urandom_range(3));
            end
        endcase
    endtask

    task automatic test_random_files();
        int unsigned sent;
        int unsigned pick;
        int unsigned cut;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            steady = ($urandom_range(4) == 0);
            pick   = $urandom_range(99);
            if (pick < 8) begin
                file_bytes.delete();
                add_random($urandom_range(40, 1));
            end else begin
                build_random_file((pick < 30) ? int'($urandom_range(6, 1)) : 0);
            end
            // occasionally cut the file short anywhere
            if ($urandom_range(9) == 0) begin
                cut = $urandom_range(file_bytes.size(), 1);
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
            sent += file_bytes.size();
            stream_file(file_bytes.size());
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        byte_if.valid     <= 1'b0;
        byte_if.file_byte <= '0;
        par_size = '0;
        rearm_parser();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_tiny_files();
        test_clean_audio();
        test_header_faults();
        test_block_faults();
        test_size_rewrite();
        test_random_files();

        wait_idle();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
